FILE: design/asrc_pkg.sv
`default_nettype none
package asrc_pkg;

  localparam int DIST_W = 12;
  localparam int SPEED_W = 12;
  localparam int LANE_W = 14;
  localparam int FRIC_W = 10;
  localparam int SAFE_W = 16;
  localparam int ST_W = 2;
  localparam int A_W = 28;
  localparam int B_W = 27;
  localparam int SUM_W = 29;
  localparam int DEN_W = 29;
  localparam int NUM_W = 40;
  localparam int QUO_W = 21;
  localparam int LATENCY = QUO_W + 5;

  localparam logic [15:0] K_REACT = 16'd44145;
  localparam logic [14:0] K_SPEED2 = 15'd20000;
  localparam logic [18:0] K_DEN = 19'd317844;

  localparam logic [SPEED_W-1:0] LANE_BASE = 12'd800;
  localparam logic [SPEED_W-1:0] LANE_KNEE = 12'd1280;
  localparam logic [LANE_W-1:0] LANE_BAND = 14'd320;
  localparam logic [SAFE_W-1:0] SAFE_MAX = 16'hFFFF;

  localparam logic [0:0] REG_FRICTION = 1'b0;
  localparam logic [0:0] REG_SENS = 1'b1;

  localparam logic [1:0] SENS_FAST = 2'd1;
  localparam logic [1:0] SENS_MID = 2'd2;

  localparam logic [ST_W-1:0] ST_SAFE = 2'd0;
  localparam logic [ST_W-1:0] ST_ATTN = 2'd1;
  localparam logic [ST_W-1:0] ST_DANGER = 2'd2;

  typedef struct packed {
    logic [DIST_W-1:0] vdist;
    logic [ST_W-1:0] lstat;
    logic [ST_W-1:0] rstat;
    logic closing;
    logic fzero;
    logic last;
  } side_t;

  typedef struct packed {
    logic valid;
    side_t side;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_t;

  function automatic logic [ST_W-1:0] max_st(input logic [ST_W-1:0] a,
                                             input logic [ST_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

FILE: design/asrc_front_end.sv
`default_nettype none
module asrc_front_end
  import asrc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic [SPEED_W-1:0] own_speed,
  input  wire logic [SPEED_W-1:0] lead_speed,
  input  wire logic [DIST_W-1:0] radar_distance,
  input  wire logic [DIST_W-1:0] lidar_distance,
  input  wire logic [DIST_W-1:0] camera_distance,
  input  wire logic [LANE_W-1:0] left_lane_distance,
  input  wire logic [LANE_W-1:0] right_lane_distance,
  input  wire logic last_sample,
  input  wire logic [FRIC_W-1:0] friction,
  input  wire logic [1:0] sensitivity,
  output div_t out
);

  // stage 0: capture
  logic v0;
  logic [SPEED_W-1:0] own0, lead0;
  logic [DIST_W-1:0] rad0, lid0, cam0;
  logic [LANE_W-1:0] left0, right0;
  logic last0;
  logic [FRIC_W-1:0] f0;
  logic [2:0] t2_0;
  logic [2:0] t2_next;

  always_comb begin
    unique case (sensitivity)
      SENS_FAST: t2_next = 3'd2;
      SENS_MID: t2_next = 3'd3;
      default: t2_next = 3'd4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    own0 <= own_speed;
    lead0 <= lead_speed;
    rad0 <= radar_distance;
    lid0 <= lidar_distance;
    cam0 <= camera_distance;
    left0 <= left_lane_distance;
    right0 <= right_lane_distance;
    last0 <= last_sample;
    f0 <= friction;
    t2_0 <= t2_next;
  end

  // stage 1: median, lane levels, constant products
  logic [DIST_W-1:0] lo, hi, med;
  logic [SPEED_W-1:0] margin;
  logic [LANE_W-1:0] m_lo, m_hi;
  logic [12:0] tf;
  side_t side_next;

  always_comb begin
    lo = (rad0 < lid0) ? rad0 : lid0;
    hi = (rad0 < lid0) ? lid0 : rad0;
    if (cam0 <= lo) begin
      med = lo;
    end else if (cam0 >= hi) begin
      med = hi;
    end else begin
      med = cam0;
    end
    margin = (own0 > LANE_KNEE) ? (own0 - LANE_KNEE + LANE_BASE) : LANE_BASE;
    m_lo = LANE_W'(margin);
    m_hi = m_lo + LANE_BAND;
    side_next.vdist = med;
    side_next.lstat = (left0 < m_lo) ? ST_DANGER : ((left0 < m_hi) ? ST_ATTN : ST_SAFE);
    side_next.rstat = (right0 < m_lo) ? ST_DANGER : ((right0 < m_hi) ? ST_ATTN : ST_SAFE);
    side_next.closing = own0 > lead0;
    side_next.fzero = (f0 == '0);
    side_next.last = last0;
    tf = 13'(t2_0) * 13'(f0);
  end

  logic v1;
  side_t side1;
  logic [SPEED_W-1:0] own1;
  logic [A_W-1:0] a1;
  logic [B_W-1:0] b1;
  logic [DEN_W-1:0] den1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    side1 <= side_next;
    own1 <= own0;
    a1 <= A_W'(K_REACT) * A_W'(tf);
    b1 <= B_W'(K_SPEED2) * B_W'(own0);
    den1 <= DEN_W'(K_DEN) * DEN_W'(f0);
  end

  // stage 2: sum of terms
  logic v2;
  side_t side2;
  logic [SPEED_W-1:0] own2;
  logic [SUM_W-1:0] sum2;
  logic [DEN_W-1:0] den2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    side2 <= side1;
    own2 <= own1;
    sum2 <= SUM_W'(a1) + SUM_W'(b1);
    den2 <= den1;
  end

  // stage 3: numerator = S * (44145*T*F + 20000*S)
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= v2;
    end
    out.side <= side2;
    out.den <= den2;
    out.rem <= NUM_W'(own2) * NUM_W'(sum2);
    out.quo <= '0;
  end

endmodule
`default_nettype wire

FILE: design/asrc_div_stage.sv
`default_nettype none
module asrc_div_stage
  import asrc_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  div_t in,
  output div_t out
);

  localparam int CW = DEN_W + QUO_W;

  logic [CW-1:0] rem_w, den_w, diff;
  logic take;
  logic [QUO_W-1:0] quo_next;

  always_comb begin
    rem_w = CW'(in.rem);
    den_w = CW'(in.den) << SHIFT;
    take = rem_w >= den_w;
    diff = rem_w - den_w;
    quo_next = in.quo;
    quo_next[SHIFT] = take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= in.valid;
    end
    out.side <= in.side;
    out.den <= in.den;
    out.rem <= take ? NUM_W'(diff) : in.rem;
    out.quo <= quo_next;
  end

endmodule
`default_nettype wire

FILE: design/asrc_classify.sv
`default_nettype none
module asrc_classify
  import asrc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  div_t in,
  output logic result_valid,
  output logic [DIST_W-1:0] validated_distance,
  output logic [SAFE_W-1:0] safe_distance,
  output logic [ST_W-1:0] front_status,
  output logic [ST_W-1:0] left_status,
  output logic [ST_W-1:0] right_status,
  output logic [ST_W-1:0] overall_status,
  output logic last_out
);

  logic rem_zero, ge_full, ge_half;
  logic [DIST_W:0] d2;
  logic [SAFE_W-1:0] safe_next;
  logic [ST_W-1:0] front_next;

  always_comb begin
    rem_zero = (in.rem == '0);
    d2 = {in.side.vdist, 1'b0};
    // dist >= X and 2*dist >= X, with X = quo + rem/den
    ge_full = (in.quo[QUO_W-1:DIST_W] == '0) &&
              ((in.side.vdist > in.quo[DIST_W-1:0]) ||
               ((in.side.vdist == in.quo[DIST_W-1:0]) && rem_zero));
    ge_half = (in.quo[QUO_W-1:DIST_W+1] == '0) &&
              ((d2 > in.quo[DIST_W:0]) ||
               ((d2 == in.quo[DIST_W:0]) && rem_zero));
    if (in.side.fzero || (in.quo[QUO_W-1:SAFE_W] != '0)) begin
      safe_next = SAFE_MAX;
    end else begin
      safe_next = in.quo[SAFE_W-1:0];
    end
    if (!in.side.closing) begin
      front_next = ST_SAFE;
    end else if (in.side.fzero) begin
      front_next = ST_DANGER;
    end else if (ge_full) begin
      front_next = ST_SAFE;
    end else if (ge_half) begin
      front_next = ST_ATTN;
    end else begin
      front_next = ST_DANGER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= in.valid;
    end
    validated_distance <= in.side.vdist;
    safe_distance <= safe_next;
    front_status <= front_next;
    left_status <= in.side.lstat;
    right_status <= in.side.rstat;
    overall_status <= max_st(front_next, max_st(in.side.lstat, in.side.rstat));
    last_out <= in.side.last;
  end

endmodule
`default_nettype wire

FILE: design/adas_sample_risk_classifier.sv
// Vehicle sample risk classifier. One request is accepted on every clock
// cycle at which start is high and busy is low; busy is high only while rst
// is asserted. Each request gives exactly one result, shown on the result
// ports for one cycle with result_valid high. The receiver cannot stall
// the block and must take every result when it appears. The pipeline is
// made of four capture and multiply stages, a 21-stage restoring divider
// that produces one quotient bit per stage, and the output register.
// road_friction and sensitivity_level are sampled when a request enters;
// write them only while no request is in flight.
`default_nettype none
module adas_sample_risk_classifier
  import asrc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [SPEED_W-1:0] own_speed,
  input  wire logic [SPEED_W-1:0] lead_speed,
  input  wire logic [DIST_W-1:0] radar_distance,
  input  wire logic [DIST_W-1:0] lidar_distance,
  input  wire logic [DIST_W-1:0] camera_distance,
  input  wire logic [LANE_W-1:0] left_lane_distance,
  input  wire logic [LANE_W-1:0] right_lane_distance,
  input  wire logic last_sample,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [FRIC_W-1:0] cfg_data,
  output logic result_valid,
  output logic [DIST_W-1:0] validated_distance,
  output logic [SAFE_W-1:0] safe_distance,
  output logic [ST_W-1:0] front_status,
  output logic [ST_W-1:0] left_status,
  output logic [ST_W-1:0] right_status,
  output logic [ST_W-1:0] overall_status,
  output logic last_out
);

  logic [FRIC_W-1:0] road_friction;
  logic [1:0] sensitivity_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      road_friction <= FRIC_W'(179);
      sensitivity_level <= 2'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRICTION: road_friction <= cfg_data;
        REG_SENS: sensitivity_level <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  div_t chain [0:QUO_W];

  asrc_front_end u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(start && !busy),
    .own_speed(own_speed),
    .lead_speed(lead_speed),
    .radar_distance(radar_distance),
    .lidar_distance(lidar_distance),
    .camera_distance(camera_distance),
    .left_lane_distance(left_lane_distance),
    .right_lane_distance(right_lane_distance),
    .last_sample(last_sample),
    .friction(road_friction),
    .sensitivity(sensitivity_level),
    .out(chain[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    asrc_div_stage #(
      .SHIFT(QUO_W - 1 - i)
    ) u_stage (
      .clk(clk),
      .rst(rst),
      .in(chain[i]),
      .out(chain[i+1])
    );
  end

  asrc_classify u_class (
    .clk(clk),
    .rst(rst),
    .in(chain[QUO_W]),
    .result_valid(result_valid),
    .validated_distance(validated_distance),
    .safe_distance(safe_distance),
    .front_status(front_status),
    .left_status(left_status),
    .right_status(right_status),
    .overall_status(overall_status),
    .last_out(last_out)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result strobe right after reset");

  a_front_clear: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ({4'b0, validated_distance} > safe_distance))
    |-> (front_status == ST_SAFE))
    else $error("front risk flagged beyond safe distance");

  a_front_no_attn: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ({4'b0, validated_distance} < (safe_distance >> 1)))
    |-> (front_status != ST_ATTN))
    else $error("attention flagged below half safe distance");

endmodule
`default_nettype wire
